// ----- design/wac_pkg.sv -----
// Shared types and constants for the weighted average cost position keeper.
`timescale 1ns / 1ps
package wac_pkg;

    localparam int SLOT_W   = 10;
    localparam int QTY_W    = 32;
    localparam int PRICE_W  = 48;
    localparam int NET_W    = 48;
    localparam int COST_W   = 48;
    localparam int PROFIT_W = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [NET_W-1:0] NET_MAX_BITS = {1'b0, {(NET_W-1){1'b1}}};
    localparam logic [NET_W-1:0] NET_MIN_BITS = {1'b1, {(NET_W-1){1'b0}}};
    localparam logic [PROFIT_W-1:0] P_MAX_BITS = {1'b0, {(PROFIT_W-1){1'b1}}};
    localparam logic [PROFIT_W-1:0] P_MIN_BITS = {1'b1, {(PROFIT_W-1){1'b0}}};

    // One classified fill as it travels from the front to the back.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
        logic               zero;
        logic               neg;
    } wac_item_t;

    // Status that the back reports to the front.
    typedef struct packed {
        logic clear_done;
    } wac_status_t;

endpackage

// ----- design/wac_front.sv -----
// Front end: accepts fills, reduces the slot modulo the slot count, classifies the quantity.
`timescale 1ns / 1ps
module wac_front #(
    parameter int SLOTS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [wac_pkg::SLOT_W-1:0]  in_slot,
    input  logic [wac_pkg::QTY_W-1:0]   in_qty,
    input  logic [wac_pkg::PRICE_W-1:0] in_price,
    input  wac_pkg::wac_status_t      status,
    output logic                      push,
    output wac_pkg::wac_item_t        push_item,
    input  logic                      queue_full
);
    import wac_pkg::*;

    // Reciprocal of the slot count, scaled so that the quotient is exact for any slot field.
    localparam int     RL = $clog2(SLOTS);
    localparam int     RS = SLOT_W + RL;
    localparam longint RM = (longint'(1) << RS) / longint'(SLOTS) + 1;
    localparam int     MW = RS + SLOT_W + 2;

    typedef enum logic [1:0] {F_IDLE, F_MOD, F_PUSH} fstate_t;

    fstate_t            state_reg, state_next;
    logic [SLOT_W-1:0]  rem_reg, rem_next;
    logic [QTY_W-1:0]   qty_reg, qty_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [MW-1:0]      prod;
    logic [SLOT_W-1:0]  quo;
    logic [MW-1:0]      rem_w;

    assign in_ready = (state_reg == F_IDLE) && status.clear_done;

    // Slot reduction: quotient by the scaled reciprocal, then one multiply and subtract.
    assign prod  = MW'(rem_reg) * MW'(RM);
    assign quo   = prod[RS +: SLOT_W];
    assign rem_w = MW'(rem_reg) - MW'(quo) * MW'(SLOTS);

    assign push_item.slot  = rem_reg;
    assign push_item.qty   = qty_reg;
    assign push_item.price = price_reg;
    assign push_item.zero  = (qty_reg == '0);
    assign push_item.neg   = qty_reg[QTY_W-1];
    assign push = (state_reg == F_PUSH) && !queue_full;

    // Accept, reduce the slot in the F_MOD state, then hand the item to the queue.
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        qty_next   = qty_reg;
        price_next = price_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    rem_next   = in_slot;
                    qty_next   = in_qty;
                    price_next = in_price;
                    state_next = F_MOD;
                end
            end
            F_MOD:
            begin
                rem_next   = rem_w[SLOT_W-1:0];
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        qty_reg   <= qty_next;
        price_reg <= price_next;
    end

endmodule

// ----- design/wac_queue.sv -----
// Short queue of classified fills between the front and the back.
`timescale 1ns / 1ps
module wac_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  wac_pkg::wac_item_t push_item,
    output logic               full,
    input  logic               pop,
    output wac_pkg::wac_item_t head,
    output logic               empty
);
    import wac_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    wac_item_t       slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slots_reg[rd_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= push_item;
        end
    end

endmodule

// ----- design/wac_back.sv -----
// Back end: position store, shift-add multiplier, restoring divider and result register.
`timescale 1ns / 1ps
module wac_back #(
    parameter int SLOTS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wac_pkg::wac_item_t           head,
    input  logic                         empty,
    output logic                         pop,
    output wac_pkg::wac_status_t         status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wac_pkg::SLOT_W-1:0]   out_slot,
    output logic [wac_pkg::NET_W-1:0]    out_net,
    output logic [wac_pkg::COST_W-1:0]   out_cost,
    output logic [wac_pkg::PROFIT_W-1:0] out_profit
);
    import wac_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int AW = 97;

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_LOAD, B_MUL, B_DIV, B_UPD, B_WRITE} bstate_t;

    typedef struct packed {
        logic [NET_W-1:0]    net;
        logic [COST_W-1:0]   cost;
        logic [PROFIT_W-1:0] profit;
    } entry_t;

    entry_t store_mem [SLOTS];
    entry_t rd_data_reg;

    bstate_t             state_reg, state_next;
    logic [SW-1:0]       clr_reg, clr_next;
    wac_item_t           it_reg, it_next;
    entry_t              old_reg, old_next;
    entry_t              res_reg, res_next;
    logic [95:0]         a1_reg, a1_next, a2_reg, a2_next;
    logic [COST_W-1:0]   m1_reg, m1_next, m2_reg, m2_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic [NET_W:0]      den_reg, den_next;
    logic [NET_W-1:0]    rem_reg, rem_next;
    logic [COST_W-1:0]   q_reg, q_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic                same_reg, same_next, up_reg, up_next, long_reg, long_next;
    logic                ov_reg, ov_next;
    logic [SLOT_W-1:0]   oslot_reg, oslot_next;
    entry_t              oent_reg, oent_next;

    logic                we;
    logic [SW-1:0]       wa;
    entry_t              wd;
    logic [SW-1:0]       ra;

    // Working values of the load and update steps.
    logic [NET_W-1:0]    an, closing, aq_w;
    logic [QTY_W-1:0]    aq;
    logic [PRICE_W-1:0]  diff;
    logic                same_c, up_c;
    logic [NET_W:0]      den_c;
    logic [NET_W:0]      dr;
    logic                dge;
    logic [NET_W:0]      nsum;
    logic [NET_W-1:0]    nn;
    logic [PROFIT_W-1:0] mag;
    logic [PROFIT_W+1:0] ps;
    logic [PROFIT_W-1:0] pnew;
    logic                pneg;
    logic                out_free;

    assign status.clear_done = (state_reg != B_CLEAR);
    assign pop      = (state_reg == B_IDLE) && !empty;
    assign ra       = SW'(head.slot);
    assign out_free = !ov_reg || out_ready;

    assign out_valid  = ov_reg;
    assign out_slot   = oslot_reg;
    assign out_net    = oent_reg.net;
    assign out_cost   = oent_reg.cost;
    assign out_profit = oent_reg.profit;

    // Classification of the fill against the stored position.
    always_comb
    begin
        an      = old_next.net[NET_W-1] ? NET_W'(-old_next.net) : old_next.net;
        aq      = it_reg.neg ? QTY_W'(-it_reg.qty) : it_reg.qty;
        aq_w    = NET_W'(aq);
        closing = (aq_w < an) ? aq_w : an;
        same_c  = (old_next.net == '0) || (old_next.net[NET_W-1] == it_reg.neg);
        up_c    = it_reg.price >= old_next.cost;
        diff    = up_c ? it_reg.price - old_next.cost : old_next.cost - it_reg.price;
        den_c   = {1'b0, an} + {1'b0, aq_w};
    end

    // One divider step: shift in a numerator bit and subtract the divisor when it fits.
    always_comb
    begin
        dr  = {rem_reg, acc_reg[AW-1]};
        dge = (dr >= den_reg);
    end

    // Net update with saturation and the saturating profit add.
    always_comb
    begin
        nsum = {old_reg.net[NET_W-1], old_reg.net} +
               {{(NET_W+1-QTY_W){it_reg.qty[QTY_W-1]}}, it_reg.qty};
        if (nsum[NET_W] != nsum[NET_W-1])
        begin
            nn = nsum[NET_W] ? NET_MIN_BITS : NET_MAX_BITS;
        end
        else
        begin
            nn = nsum[NET_W-1:0];
        end
        mag  = (acc_reg[AW-1:PROFIT_W] != '0) ? '1 : acc_reg[PROFIT_W-1:0];
        pneg = (up_reg != long_reg);
        ps   = {{2{old_reg.profit[PROFIT_W-1]}}, old_reg.profit} +
               (pneg ? (PROFIT_W+2)'(-{2'b00, mag}) : {2'b00, mag});
        if (!ps[PROFIT_W+1] && (ps[PROFIT_W:PROFIT_W-1] != 2'b00))
        begin
            pnew = P_MAX_BITS;
        end
        else if (ps[PROFIT_W+1] && (ps[PROFIT_W:PROFIT_W-1] != 2'b11))
        begin
            pnew = P_MIN_BITS;
        end
        else
        begin
            pnew = ps[PROFIT_W-1:0];
        end
    end

    // Sequencer of the back end.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        it_next    = it_reg;
        old_next   = old_reg;
        res_next   = res_reg;
        a1_next    = a1_reg;
        a2_next    = a2_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        acc_next   = acc_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        same_next  = same_reg;
        up_next    = up_reg;
        long_next  = long_reg;
        ov_next    = ov_reg && !out_ready;
        oslot_next = oslot_reg;
        oent_next  = oent_reg;
        we = 1'b0;
        wa = SW'(it_reg.slot);
        wd = res_reg;
        if (state_reg == B_LOAD)
        begin
            old_next = rd_data_reg;
        end
        case (state_reg)
            B_CLEAR:
            begin
                we = 1'b1;
                wa = clr_reg;
                wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SW'(SLOTS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    it_next    = head;
                    state_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                same_next = same_c;
                up_next   = up_c;
                long_next = !old_next.net[NET_W-1] && (old_next.net != '0);
                den_next  = den_c;
                a1_next   = 96'(same_c ? an : closing);
                a2_next   = same_c ? 96'(aq) : '0;
                m1_next   = same_c ? old_next.cost : diff;
                m2_next   = it_reg.price;
                acc_next  = same_c ? AW'(den_c[NET_W:1]) : '0;
                rem_next  = '0;
                cnt_next  = '0;
                res_next  = old_next;
                state_next = it_reg.zero ? B_WRITE : B_MUL;
            end
            B_MUL:
            begin
                acc_next = acc_reg + (m1_reg[0] ? AW'(a1_reg) : '0)
                                   + (m2_reg[0] ? AW'(a2_reg) : '0);
                a1_next  = a1_reg << 1;
                a2_next  = a2_reg << 1;
                m1_next  = m1_reg >> 1;
                m2_next  = m2_reg >> 1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(COST_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = same_reg ? B_DIV : B_UPD;
                end
            end
            B_DIV:
            begin
                rem_next = dge ? NET_W'(dr - den_reg) : dr[NET_W-1:0];
                q_next   = {q_reg[COST_W-2:0], dge};
                acc_next = acc_reg << 1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(AW - 1))
                begin
                    state_next = B_UPD;
                end
            end
            B_UPD:
            begin
                res_next.net = nn;
                if (same_reg)
                begin
                    res_next.cost = q_reg;
                end
                else
                begin
                    res_next.profit = pnew;
                    if (nn == '0)
                    begin
                        res_next.cost = '0;
                    end
                    else if ((!nn[NET_W-1]) != long_reg)
                    begin
                        res_next.cost = it_reg.price;
                    end
                end
                state_next = B_WRITE;
            end
            B_WRITE:
            begin
                if (out_free)
                begin
                    we         = 1'b1;
                    ov_next    = 1'b1;
                    oslot_next = it_reg.slot;
                    oent_next  = res_reg;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg    <= it_next;
        old_reg   <= old_next;
        res_reg   <= res_next;
        a1_reg    <= a1_next;
        a2_reg    <= a2_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        acc_reg   <= acc_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        same_reg  <= same_next;
        up_reg    <= up_next;
        long_reg  <= long_next;
        oslot_reg <= oslot_next;
        oent_reg  <= oent_next;
    end

    // Position store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wa] <= wd;
        end
        rd_data_reg <= store_mem[ra];
    end

endmodule

// ----- design/wac_position_pnl_keeper_unit.sv -----
// Top level of the weighted average cost position and profit keeper.
//
//  channel  | direction | fields (lowest bit first)
//  ---------+-----------+--------------------------------------------------------
//  s_axis   | in        | tdata: position_slot[9:0], fill_qty[41:10], price[89:42]
//  m_axis   | out       | tdata: slot_out[9:0], net_position[57:10],
//           |           |        average_cost[105:58], realized_profit[169:106]
//
// The front takes an item through acceptance, slot reduction and the push to the queue.
// A same-direction fill passes in the back end through pop, store read, the shift-add
// multiplier, the restoring divider, update and write. Opposite fills skip the divider;
// zero fills go from the store read straight to the write. After reset the store is
// cleared, one entry a cycle, through all SLOTS entries; no item is accepted during
// that pass. A two-item queue and the result register let input acceptance continue
// while a result waits on a stalled output.
`timescale 1ns / 1ps
module wac_position_pnl_keeper_unit #(
    parameter int SLOTS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // position_slot, fill_qty, price, zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [175:0] m_axis_tdata    // slot_out, net_position, average_cost,
                                         // realized_profit, zero pad
);
    import wac_pkg::*;

    wac_status_t          status;
    wac_item_t            push_item, head;
    logic                 push, pop, full, empty;
    logic [SLOT_W-1:0]    o_slot;
    logic [NET_W-1:0]     o_net;
    logic [COST_W-1:0]    o_cost;
    logic [PROFIT_W-1:0]  o_profit;

    wac_front #(.SLOTS(SLOTS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_slot    (s_axis_tdata[9:0]),
        .in_qty     (s_axis_tdata[41:10]),
        .in_price   (s_axis_tdata[89:42]),
        .status     (status),
        .push       (push),
        .push_item  (push_item),
        .queue_full (full)
    );

    wac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    wac_back #(.SLOTS(SLOTS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_slot   (o_slot),
        .out_net    (o_net),
        .out_cost   (o_cost),
        .out_profit (o_profit)
    );

    assign m_axis_tdata = {6'b0, o_profit, o_cost, o_net, o_slot};

endmodule

// ----- test/wac_fill_checker.sv -----
// Checker that predicts and compares the position keeper's result items.
`timescale 1ns / 1ps
module wac_fill_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // position_slot, fill_qty, price, zero pad
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [175:0] m_axis_tdata,   // slot_out, net_position, average_cost,
                                         // realized_profit, zero pad
    output int           fail_count,
    output int           open_count,
    output int           result_count
);
    import wac_pkg::*;

    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic [NET_W-1:0]    net;
        logic [COST_W-1:0]   cost;
        logic [PROFIT_W-1:0] profit;
    } slot_state_t;

    localparam longint NET_HI = 64'sd140737488355327;
    localparam longint NET_LO = -64'sd140737488355328;

    // Model copy of the three per-slot stores.
    longint              net_tab    [1024];
    logic [COST_W-1:0]   cost_tab   [1024];
    logic [PROFIT_W-1:0] profit_tab [1024];
    slot_state_t         expected_states [$];

    function automatic longint clamp_lots(longint v);
        if (v > NET_HI) return NET_HI;
        if (v < NET_LO) return NET_LO;
        return v;
    endfunction

    // Apply one fill to the model and return the slot's new state.
    function automatic slot_state_t predict_fill(logic [9:0] slot, logic [31:0] qbits,
                                                 logic [47:0] price);
        longint        net;
        longint        q;
        longint        nn;
        logic [47:0]   cost;
        logic [63:0]   an, aq, den, closing, diff, mag, p, room;
        logic [127:0]  num, prod;
        logic          up, long_pos, neg;
        slot_state_t   r;
        net  = net_tab[slot];
        cost = cost_tab[slot];
        q    = longint'($signed(qbits));
        if (q != 0) begin
            an = (net < 0) ? 64'(-net) : 64'(net);
            aq = (q < 0) ? 64'(-q) : 64'(q);
            if (net == 0 || ((net > 0) == (q > 0))) begin
                // Same direction: exact weighted mean, rounded half up.
                den = an + aq;
                num = 128'(an) * 128'(cost) + 128'(aq) * 128'(price) + 128'(den >> 1);
                cost_tab[slot] = 48'(num / 128'(den));
                net_tab[slot]  = clamp_lots(net + q);
            end
            else begin
                // Opposite direction: realize profit on the closed lots.
                closing  = (aq < an) ? aq : an;
                up       = price >= cost;
                diff     = up ? 64'(price - cost) : 64'(cost - price);
                long_pos = net > 0;
                prod     = 128'(closing) * 128'(diff);
                mag      = (prod[127:64] != 0) ? '1 : prod[63:0];
                neg      = up != long_pos;
                p        = profit_tab[slot];
                if (!neg) begin
                    room = P_MAX_BITS - p;
                    profit_tab[slot] = (mag > room) ? P_MAX_BITS : p + mag;
                end
                else begin
                    room = p - P_MIN_BITS;
                    profit_tab[slot] = (mag > room) ? P_MIN_BITS : p - mag;
                end
                nn = clamp_lots(net + q);
                net_tab[slot] = nn;
                if (nn == 0)
                    cost_tab[slot] = '0;
                else if ((nn > 0) != long_pos)
                    cost_tab[slot] = price;
            end
        end
        r.slot   = slot;
        r.net    = 48'(net_tab[slot]);
        r.cost   = cost_tab[slot];
        r.profit = profit_tab[slot];
        return r;
    endfunction

    assign open_count = expected_states.size();

    // Predict on every accepted fill, compare on every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        slot_state_t e;
        int          errs;
        errs = 0;
        if (!rst_n) begin
            for (int i = 0; i < 1024; i++) begin
                net_tab[i]    = 0;
                cost_tab[i]   = '0;
                profit_tab[i] = '0;
            end
            expected_states.delete();
            fail_count   <= 0;
            result_count <= 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_states.push_back(predict_fill(s_axis_tdata[9:0],
                                                       s_axis_tdata[41:10],
                                                       s_axis_tdata[89:42]));
            if (m_axis_tvalid && m_axis_tready) begin
                result_count <= result_count + 1;
                if (expected_states.size() == 0) begin
                    $error("result item with no fill waiting");
                    errs++;
                end
                else begin
                    e = expected_states.pop_front();
                    if (m_axis_tdata[9:0] !== e.slot) begin
                        $error("slot_out: expected %0d, got %0d", e.slot, m_axis_tdata[9:0]);
                        errs++;
                    end
                    if (m_axis_tdata[57:10] !== e.net) begin
                        $error("net_position: expected %0d, got %0d",
                               $signed(e.net), $signed(m_axis_tdata[57:10]));
                        errs++;
                    end
                    if (m_axis_tdata[105:58] !== e.cost) begin
                        $error("average_cost: expected %h, got %h",
                               e.cost, m_axis_tdata[105:58]);
                        errs++;
                    end
                    if (m_axis_tdata[169:106] !== e.profit) begin
                        $error("realized_profit: expected %h, got %h",
                               e.profit, m_axis_tdata[169:106]);
                        errs++;
                    end
                end
                if (errs != 0)
                    fail_count <= fail_count + errs;
            end
        end
    end

endmodule

// ----- test/tb.sv -----
// Top of the position keeper testbench: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb;
    import wac_pkg::*;

    localparam int RANDOM_FILLS = 1500;
    localparam int IDLE_LIMIT   = 50000;
    localparam int LONG_HOLD    = 2000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;    // position_slot, fill_qty, price, zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;         // slot_out, net_position, average_cost,
                                        // realized_profit, zero pad
    int           fail_count;
    int           open_count;
    int           result_count;
    int           idle_cycles = 0;
    int           fills_sent = 0;

    wac_position_pnl_keeper_unit #(.SLOTS(1024)) dut (.*);

    wac_fill_checker chk (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Drive one fill after a random gap and hold it until it is accepted.
    task automatic send_fill(logic [9:0] slot, logic [31:0] qty, logic [47:0] price);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, price, qty, slot};
        do @(posedge clk); while (!s_axis_tready);
        fills_sent++;
    endtask

    function automatic logic [31:0] pick_qty();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return $urandom_range(1, 100) * (($urandom_range(0, 1) != 0) ? 1 : -1);
        if (k < 70) return $urandom();
        if (k < 75) return '0;
        if (k < 80) return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
        return $urandom_range(1, 1 << 20) * (($urandom_range(0, 1) != 0) ? 1 : -1);
    endfunction

    function automatic logic [47:0] pick_price();
        int k;
        k = $urandom_range(0, 99);
        if (k < 20) return 48'({$urandom(), $urandom()});
        if (k < 23) return '0;
        if (k < 26) return '1;
        return (48'd100 << 16) + 48'($urandom_range(0, 1 << 22)) - 48'(1 << 21);
    endfunction

    // Result side: random ready gaps, one long hold to fill the block up.
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!held && result_count >= 200) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results open", open_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed fills: extremes, zero fill, flips, closing to flat, saturation.
        send_fill(10'd0, 32'd0, 48'd0);
        send_fill(10'd1023, 32'd10, 48'hffff_ffff_ffff);
        send_fill(10'd1023, 32'd0, 48'd5);
        send_fill(10'd1023, -32'sd10, 48'd0);
        send_fill(10'd1, 32'd3, 48'd7);
        send_fill(10'd1, 32'd4, 48'd8);
        send_fill(10'd1, -32'sd2, 48'd9);
        send_fill(10'd1, -32'sd10, 48'd3);
        send_fill(10'd1, 32'd5, 48'd1);
        send_fill(10'd2, 32'h7fff_ffff, 48'd0);
        send_fill(10'd2, 32'h8000_0000, 48'hffff_ffff_ffff);
        send_fill(10'd2, 32'h7fff_ffff, 48'd0);
        send_fill(10'd2, 32'h7fff_ffff, 48'hffff_ffff_ffff);
        send_fill(10'd2, 32'h8000_0000, 48'd0);
        send_fill(10'd3, 32'h8000_0000, 48'hffff_ffff_ffff);
        send_fill(10'd3, 32'h8000_0000, 48'h8000_0000_0001);
        send_fill(10'd3, 32'h7fff_ffff, 48'd0);
        send_fill(10'd3, 32'h7fff_ffff, 48'd0);
        send_fill(10'd4, 32'd1, 48'd1);
        send_fill(10'd4, 32'd2, 48'd2);
        send_fill(10'd4, -32'sd3, 48'd2);
        send_fill(10'd512, 32'h5555_5555, 48'haaaa_aaaa_aaaa);

        // Random fills, mostly on a few hot slots so positions build up.
        for (int i = 0; i < RANDOM_FILLS; i++) begin
            if ($urandom_range(0, 9) < 7)
                send_fill(10'($urandom_range(0, 7)), pick_qty(), pick_price());
            else
                send_fill(10'($urandom()), pick_qty(), pick_price());
        end
        s_axis_tvalid <= 1'b0;

        while (open_count != 0) @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Sent %0d fills over hot and spread slots, checked %0d results,",
                 fills_sent, result_count);
        $display("with flips, flat closes, extreme lots and prices, and a long output stall.");
        if (fail_count == 0 && open_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
